[rtl/core/hhq_pkg.sv]
`timescale 1ns / 1ps
package hhq_pkg;
    localparam int GRID_SIDE = 64;
    localparam int IDX_W = $clog2(GRID_SIDE);
    localparam int BANK_DEPTH = GRID_SIDE * GRID_SIDE / 4;
    localparam int BANK_AW = 2 * IDX_W - 2;
    localparam logic signed [31:0] OUTSIDE_HEIGHT = -32'sd58982400;
    localparam logic [16:0] Q_ONE = 17'd65536;

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_TILE_W = 3'd3;
    localparam logic [2:0] REG_INV_TILE_W = 3'd4;
    localparam logic [2:0] REG_GRID_VERT = 3'd5;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic              kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_z;
        logic [5:0]        sample_row;
        logic [5:0]        sample_col;
        logic signed [31:0] sample_value;
    } hhq_in_t;

    typedef struct packed {
        logic signed [31:0] height;
        logic              outside;
    } hhq_out_t;

    typedef struct packed {
        logic [IDX_W-1:0] tx;
        logic [IDX_W-1:0] tz;
        logic [15:0]      fx;
        logic [15:0]      fz;
        logic             outside;
    } hhq_loc_t;
endpackage

[rtl/core/hhq_locate.sv]
`timescale 1ns / 1ps
// Two stages: position minus origin, then times reciprocal; the tile/fraction split is combinational.
module hhq_locate
    import hhq_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_z,
    input  logic [30:0]        inv_width,
    input  logic [6:0]         grid_vertices,
    output hhq_loc_t           loc
);
    logic signed [32:0] dx_reg, dz_reg;
    logic signed [64:0] px_reg, pz_reg;
    logic [6:0]         nv;
    logic               out_any;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= 33'(pos_x) - 33'(origin_x);
            dz_reg <= 33'(pos_z) - 33'(origin_z);
            px_reg <= 65'(dx_reg) * $signed({34'd0, inv_width});
            pz_reg <= 65'(dz_reg) * $signed({34'd0, inv_width});
        end
    end

    always_comb
    begin
        nv = (grid_vertices > 7'(GRID_SIDE)) ? 7'(GRID_SIDE) : grid_vertices;
        out_any = (nv < 7'd2) || px_reg[64] || pz_reg[64]
            || (px_reg[63:32] >= 32'(nv - 7'd1)) || (pz_reg[63:32] >= 32'(nv - 7'd1));
        loc.outside = out_any;
        loc.tx = px_reg[32 +: IDX_W];
        loc.tz = pz_reg[32 +: IDX_W];
        loc.fx = px_reg[31:16];
        loc.fz = pz_reg[31:16];
    end
endmodule

[rtl/core/hhq_interp.sv]
`timescale 1ns / 1ps
// Weights, three products, then sum and floor.
module hhq_interp
    import hhq_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] h00,
    input  logic signed [31:0] h10,
    input  logic signed [31:0] h01,
    input  logic signed [31:0] h11,
    input  logic [15:0]        fx,
    input  logic [15:0]        fz,
    output logic signed [31:0] interp
);
    logic [16:0]        sum;
    logic               upper;
    logic signed [31:0] a, b, c;
    logic [17:0]        wa, wb, wc;
    logic signed [50:0] pa_reg, pb_reg, pc_reg;
    logic signed [52:0] acc;

    always_comb
    begin
        sum = 17'(fx) + 17'(fz);
        upper = sum > Q_ONE;
        if (upper)
        begin
            a = h10; wa = 18'(Q_ONE) - 18'(fz);
            b = h11; wb = 18'(sum) - 18'(Q_ONE);
            c = h01; wc = 18'(Q_ONE) - 18'(fx);
        end
        else
        begin
            a = h00; wa = 18'(Q_ONE) - 18'(sum);
            b = h10; wb = 18'(fx);
            c = h01; wc = 18'(fz);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg <= 51'(a) * $signed({33'd0, wa});
            pb_reg <= 51'(b) * $signed({33'd0, wb});
            pc_reg <= 51'(c) * $signed({33'd0, wc});
        end
    end

    assign acc = 53'(pa_reg) + 53'(pb_reg) + 53'(pc_reg);
    // Arithmetic shift is the floor. The weights sum to one, so the result is a
    // weighted average of 32-bit samples and fits back into 32 bits.
    assign interp = 32'(acc >>> 16);
endmodule

[rtl/core/heightmap_height_query_core.sv]
`timescale 1ns / 1ps
// Channel | Signals                        | Payload
// in      | in_valid, in_stall             | hhq_in_t  (kind, pos, sample)
// out     | out_valid, out_stall           | hhq_out_t (height, outside)
// cfg     | cfg_we, cfg_index, cfg_data    | registers 0..5
// One item per cycle while no result waits under out_stall.
// The whole pipeline holds while a result waits under out_stall, so in_stall is
// high exactly in those cycles.
// Writes give no result. They travel two stages and update their parity bank at
// the stage where queries read their four samples, so each query sees exactly
// the writes accepted before it. Samples are undefined until written.
// Reset clears valid bits and configuration only.
module heightmap_height_query_core
    import hhq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  hhq_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output hhq_out_t    out_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic signed [31:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [30:0]        tile_w_reg, inv_w_reg;
    logic [6:0]         grid_vert_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0; origin_y_reg <= '0; origin_z_reg <= '0;
            tile_w_reg <= 31'd65536; inv_w_reg <= 31'd65536;
            grid_vert_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN_X:   origin_x_reg <= cfg_data;
                REG_ORIGIN_Y:   origin_y_reg <= cfg_data;
                REG_ORIGIN_Z:   origin_z_reg <= cfg_data;
                REG_TILE_W:     tile_w_reg <= cfg_data[30:0];
                REG_INV_TILE_W: inv_w_reg <= cfg_data[30:0];
                REG_GRID_VERT:  grid_vert_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Stages: 1 subtract, 2 multiply, 3 bank read, 4 weight products,
    // 5 sum and scale product, 6 offset/saturate into out register.
    logic [6:1] v_reg;
    logic       adv;
    assign adv = !(out_valid && out_stall);
    assign in_stall = !adv;
    logic acc_in;
    assign acc_in = in_valid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[5:1], acc_in && in_data.kind == KIND_QUERY};
    end

    // Write items follow the first two stages and reach the banks at stage 3.
    logic               wv1_reg, wv2_reg;
    logic [IDX_W-1:0]   wrow1_reg, wcol1_reg, wrow2_reg, wcol2_reg;
    logic signed [31:0] wval1_reg, wval2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wv1_reg <= 1'b0;
            wv2_reg <= 1'b0;
        end
        else if (adv)
        begin
            wv1_reg <= acc_in && in_data.kind == KIND_WRITE;
            wv2_reg <= wv1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wrow1_reg <= in_data.sample_row;
            wcol1_reg <= in_data.sample_col;
            wval1_reg <= in_data.sample_value;
            wrow2_reg <= wrow1_reg;
            wcol2_reg <= wcol1_reg;
            wval2_reg <= wval1_reg;
        end
    end

    hhq_loc_t loc;
    hhq_locate u_loc (
        .clk(clk), .en(adv), .pos_x(in_data.pos_x), .pos_z(in_data.pos_z),
        .origin_x(origin_x_reg), .origin_z(origin_z_reg),
        .inv_width(inv_w_reg), .grid_vertices(grid_vert_reg), .loc(loc)
    );

    // Parity banks: bank {row[0],col[0]}, address {row>>1,col>>1}.
    logic signed [31:0] bank0 [BANK_DEPTH];
    logic signed [31:0] bank1 [BANK_DEPTH];
    logic signed [31:0] bank2 [BANK_DEPTH];
    logic signed [31:0] bank3 [BANK_DEPTH];
    logic [IDX_W-1:0] tx1, tz1;
    logic [BANK_AW-1:0] a0, a1, a2, a3, wa;
    logic signed [31:0] q0_reg, q1_reg, q2_reg, q3_reg;
    logic [1:0] par_reg;
    hhq_loc_t loc3_reg;

    always_comb
    begin
        tx1 = loc.tx + IDX_W'(1);
        tz1 = loc.tz + IDX_W'(1);
        // Bank b holds the corner whose row/col parity equals b.
        a0 = {(loc.tx[0] ? tx1[IDX_W-1:1] : loc.tx[IDX_W-1:1]),
              (loc.tz[0] ? tz1[IDX_W-1:1] : loc.tz[IDX_W-1:1])};
        a1 = {(loc.tx[0] ? tx1[IDX_W-1:1] : loc.tx[IDX_W-1:1]),
              (loc.tz[0] ? loc.tz[IDX_W-1:1] : tz1[IDX_W-1:1])};
        a2 = {(loc.tx[0] ? loc.tx[IDX_W-1:1] : tx1[IDX_W-1:1]),
              (loc.tz[0] ? tz1[IDX_W-1:1] : loc.tz[IDX_W-1:1])};
        a3 = {(loc.tx[0] ? loc.tx[IDX_W-1:1] : tx1[IDX_W-1:1]),
              (loc.tz[0] ? loc.tz[IDX_W-1:1] : tz1[IDX_W-1:1])};
        wa = {wrow2_reg[IDX_W-1:1], wcol2_reg[IDX_W-1:1]};
    end

    always_ff @(posedge clk)
    begin
        if (adv && wv2_reg)
        begin
            case ({wrow2_reg[0], wcol2_reg[0]})
                2'd0: bank0[wa] <= wval2_reg;
                2'd1: bank1[wa] <= wval2_reg;
                2'd2: bank2[wa] <= wval2_reg;
                default: bank3[wa] <= wval2_reg;
            endcase
        end
        if (adv)
        begin
            q0_reg <= bank0[a0]; q1_reg <= bank1[a1];
            q2_reg <= bank2[a2]; q3_reg <= bank3[a3];
            par_reg <= {loc.tx[0], loc.tz[0]};
            loc3_reg <= loc;
        end
    end

    logic signed [31:0] q [4];
    logic signed [31:0] h00, h10, h01, h11;
    always_comb
    begin
        q[0] = q0_reg; q[1] = q1_reg; q[2] = q2_reg; q[3] = q3_reg;
        h00 = q[par_reg];
        h01 = q[{par_reg[1], ~par_reg[0]}];
        h10 = q[{~par_reg[1], par_reg[0]}];
        h11 = q[~par_reg];
    end

    logic signed [31:0] interp;
    logic out4_reg, out5_reg;
    hhq_interp u_int (
        .clk(clk), .en(adv), .h00(h00), .h10(h10), .h01(h01), .h11(h11),
        .fx(loc3_reg.fx), .fz(loc3_reg.fz), .interp(interp)
    );

    logic signed [63:0] scaled_reg;
    logic signed [65:0] hsum;
    hhq_out_t res_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out4_reg <= loc3_reg.outside;
            out5_reg <= out4_reg;
            scaled_reg <= 64'(interp) * $signed({33'd0, tile_w_reg});
        end
    end

    assign hsum = 66'(scaled_reg >>> 16) + 66'(origin_y_reg);
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg.outside <= out5_reg;
            if (out5_reg)
                res_reg.height <= OUTSIDE_HEIGHT;
            else if (hsum > 66'sd2147483647)
                res_reg.height <= 32'sh7fffffff;
            else if (hsum < -66'sd2147483648)
                res_reg.height <= 32'sh80000000;
            else
                res_reg.height <= hsum[31:0];
        end
    end

    assign out_valid = v_reg[6];
    assign out_data = res_reg;

    property p_stall_hold;
        @(posedge clk) disable iff (!rst_n)
            out_valid && out_stall |=> out_valid && $stable(out_data);
    endproperty
    a_stall_hold: assert property (p_stall_hold) else $error("result changed under stall");
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid) else $error("input stalled without full output");
    a_outside_h: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.outside |-> out_data.height == OUTSIDE_HEIGHT)
        else $error("outside result has wrong height");
endmodule

[sim/hhq_checker.sv]
`timescale 1ns / 1ps
module hhq_checker
    import hhq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  hhq_in_t     in_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  hhq_out_t    out_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          errors,
    output int          pending
);
    logic signed [31:0] org_x, org_y, org_z;
    logic [30:0]        tile_w, inv_tile_w;
    logic [6:0]         grid_vert;
    logic signed [31:0] samples [GRID_SIDE*GRID_SIDE];
    hhq_out_t           heights_due [$];

    function automatic logic signed [63:0] floor16(logic signed [63:0] v);
        return v >>> 16;
    endfunction

    function automatic hhq_out_t height_at(hhq_in_t q);
        hhq_out_t r;
        int unsigned nv;
        logic signed [63:0] px, pz, acc, interp, h;
        logic signed [63:0] fx, fz, h00, h10, h01, h11;
        int tx, tz;
        nv = (grid_vert > GRID_SIDE) ? GRID_SIDE : grid_vert;
        px = (64'(q.pos_x) - 64'(org_x)) * $signed({33'd0, inv_tile_w});
        pz = (64'(q.pos_z) - 64'(org_z)) * $signed({33'd0, inv_tile_w});
        if (nv < 2 || px < 0 || pz < 0 || px[63:32] >= nv - 1 || pz[63:32] >= nv - 1)
        begin
            r.height = OUTSIDE_HEIGHT;
            r.outside = 1'b1;
            return r;
        end
        tx = int'(px[63:32]);
        tz = int'(pz[63:32]);
        fx = {48'd0, px[31:16]};
        fz = {48'd0, pz[31:16]};
        h00 = samples[tx*GRID_SIDE + tz];
        h10 = samples[(tx+1)*GRID_SIDE + tz];
        h01 = samples[tx*GRID_SIDE + tz + 1];
        h11 = samples[(tx+1)*GRID_SIDE + tz + 1];
        if (fx + fz <= 65536)
            acc = h00*(65536 - fx - fz) + h10*fx + h01*fz;
        else
            acc = h10*(65536 - fz) + h11*(fx + fz - 65536) + h01*(65536 - fx);
        interp = floor16(acc);
        h = floor16(interp * $signed({33'd0, tile_w})) + 64'(org_y);
        if (h > 64'sd2147483647)
            h = 64'sd2147483647;
        if (h < -64'sd2147483648)
            h = -64'sd2147483648;
        r.height = h[31:0];
        r.outside = 1'b0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hhq_out_t due;
        if (!rst_n)
        begin
            org_x <= '0;
            org_y <= '0;
            org_z <= '0;
            tile_w <= 31'd65536;
            inv_tile_w <= 31'd65536;
            grid_vert <= 7'd64;
            errors <= 0;
            pending <= 0;
            heights_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ORIGIN_X: org_x <= cfg_data;
                    REG_ORIGIN_Y: org_y <= cfg_data;
                    REG_ORIGIN_Z: org_z <= cfg_data;
                    REG_TILE_W: tile_w <= cfg_data[30:0];
                    REG_INV_TILE_W: inv_tile_w <= cfg_data[30:0];
                    REG_GRID_VERT: grid_vert <= cfg_data[6:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (heights_due.size() == 0)
                begin
                    $display("%t: unexpected result height=%0d outside=%0b", $realtime,
                             out_data.height, out_data.outside);
                    errors <= errors + 1;
                end
                else
                begin
                    due = heights_due.pop_front();
                    if (due.height !== out_data.height || due.outside !== out_data.outside)
                    begin
                        $display({"%t: mismatch expected height=%0d outside=%0b,",
                                  " actual height=%0d outside=%0b"},
                                 $realtime, due.height, due.outside, out_data.height,
                                 out_data.outside);
                        errors <= errors + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (in_data.kind == KIND_WRITE)
                    samples[in_data.sample_row*GRID_SIDE + in_data.sample_col] =
                        in_data.sample_value;
                else
                    heights_due.insert(heights_due.size(), height_at(in_data));
            end
            pending <= heights_due.size();
        end
    end
endmodule

[sim/tb_heightmap_height_query_core.sv]
`timescale 1ns / 1ps
module tb_heightmap_height_query_core;
    import hhq_pkg::*;

    // Side of the grid corner written before the directed queries; random phases write anywhere.
    localparam int WR_SIDE = 12;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    hhq_in_t     in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    hhq_out_t    out_data;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int          errors, pending;
    int          send_idle_pct = 0, recv_idle_pct = 0;
    bit          hold_recv = 1'b0;
    int          cycles = 0;
    int unsigned nv_now = 64;
    logic [30:0] inv_now = 31'd65536;
    logic signed [31:0] ox_now = 0, oz_now = 0;

    always #5 clk = ~clk;

    heightmap_height_query_core i_dut (.*);

    hhq_checker i_checker (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver stall: random, or forced high while the long hold-off is on.
    always @(posedge clk)
        out_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);

    // Valid stays high after the last accepted item until the next idle cycle,
    // drain or register write drops it.
    task automatic send_item(hhq_in_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_sample(int r, int c, logic [31:0] v);
        hhq_in_t it;
        it = '0;
        it.kind = KIND_WRITE;
        it.sample_row = 6'(r);
        it.sample_col = 6'(c);
        it.sample_value = v;
        it.pos_x = $urandom;
        it.pos_z = $urandom;
        send_item(it);
    endtask

    task automatic query_at(logic [31:0] x, logic [31:0] z);
        hhq_in_t it;
        it = '0;
        it.kind = KIND_QUERY;
        it.pos_x = x;
        it.pos_z = z;
        it.sample_row = 6'($urandom);
        it.sample_col = 6'($urandom);
        it.sample_value = $urandom;
        send_item(it);
    endtask

    // Mostly inside positions: tile index plus fraction mapped back to world units.
    task automatic query_inside();
        logic signed [63:0] wx, wz;
        if (inv_now == 31'd65536 && nv_now >= 2)
        begin
            wx = 64'(ox_now) + ($urandom_range(nv_now - 2) <<< 16) + $urandom_range(65535);
            wz = 64'(oz_now) + ($urandom_range(nv_now - 2) <<< 16) + $urandom_range(65535);
            query_at(wx[31:0], wz[31:0]);
        end
        else
            query_at($urandom, $urandom);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_reg(logic [2:0] idx, logic [31:0] v);
        in_valid <= 1'b0;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_ORIGIN_X: ox_now = v;
            REG_ORIGIN_Z: oz_now = v;
            REG_INV_TILE_W: inv_now = v[30:0];
            REG_GRID_VERT: nv_now = (v[6:0] > 64) ? 64 : v[6:0];
            default: ;
        endcase
    endtask

    task automatic random_phase(int n);
        int k;
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(3) == 0)
                write_sample($urandom_range(63), $urandom_range(63), $urandom);
            else if ($urandom_range(9) == 0)
                query_at($urandom, $urandom);
            else
                query_inside();
        end
    endtask

    initial
    begin
        int r, c;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_reg(REG_GRID_VERT, 32'(WR_SIDE));
        // Every sample that a query can reach is written first.
        send_idle_pct = 0;
        for (r = 0; r < WR_SIDE; r++)
            for (c = 0; c < WR_SIDE; c++)
                write_sample(r, c, (r == 0 && c == 0) ? 32'h7fffffff :
                             (r == WR_SIDE - 1 && c == WR_SIDE - 1) ? 32'h80000000 :
                             $urandom);
        drain();
        // Directed corners, edges and both triangles; the last inside tile is 10.
        query_at(0, 0);
        query_at(32'h0000ffff, 32'h0000ffff);
        query_at(32'h00008000, 32'h00008000);
        query_at(32'h000affff, 32'h000affff);
        query_at(32'h000b0000, 0);
        query_at(0, 32'h000b0000);
        query_at(32'hffffffff, 0);
        query_at(32'h7fffffff, 32'h80000000);
        query_at(32'h80000000, 32'h7fffffff);
        drain();
        set_reg(REG_TILE_W, 32'h7fffffff);
        set_reg(REG_ORIGIN_Y, 32'h7fffffff);
        query_at(32'h00010000, 32'h00020000);
        query_at(32'h00000001, 0);
        drain();
        set_reg(REG_ORIGIN_Y, 32'h80000000);
        set_reg(REG_TILE_W, 32'd1);
        set_reg(REG_INV_TILE_W, 32'd1);
        set_reg(REG_GRID_VERT, 32'd2);
        query_at(32'h7fffffff, 32'h7fffffff);
        query_at(32'h80000000, 32'h00000000);
        drain();
        set_reg(REG_GRID_VERT, 32'd127);
        set_reg(REG_INV_TILE_W, 32'h7fffffff);
        set_reg(REG_ORIGIN_X, 32'h80000000);
        set_reg(REG_ORIGIN_Z, 32'h7fffffff);
        drain();
        query_at(32'h80000000, 32'h7fffffff);
        query_at(32'h80000001, 32'h7fffffff);
        query_at(32'h7fffffff, 32'h80000000);
        drain();
        set_reg(REG_GRID_VERT, 32'd0);
        query_at(32'h0, 32'h0);
        drain();
        set_reg(REG_ORIGIN_X, 32'hffc00000);
        set_reg(REG_ORIGIN_Z, 32'h00100000);
        set_reg(REG_ORIGIN_Y, 32'h00050000);
        set_reg(REG_TILE_W, 32'h00020000);
        set_reg(REG_INV_TILE_W, 32'h00010000);
        set_reg(REG_GRID_VERT, 32'(WR_SIDE));
        send_idle_pct = 11;
        recv_idle_pct = 73;
        random_phase(150);
        // Long receiver hold-off so the pipeline fills and stalls its input.
        fork
            begin
                hold_recv = 1'b1;
                repeat (60) @(posedge clk);
                hold_recv = 1'b0;
            end
            random_phase(30);
        join
        drain();
        set_reg(REG_GRID_VERT, 32'd10);
        set_reg(REG_TILE_W, 32'h00008000);
        set_reg(REG_ORIGIN_Y, 32'hfff00000);
        send_idle_pct = 73;
        recv_idle_pct = 11;
        random_phase(120);
        drain();
        set_reg(REG_GRID_VERT, 32'(WR_SIDE));
        set_reg(REG_INV_TILE_W, 32'h00010000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(150);
        drain();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
